[hw/rtl/sts_pkg.sv]
// sts_pkg: shared constants, types and key helper for sorted_table_search.
// Used by sts_front, sts_queue, sts_back and the top level. No dependencies.
`timescale 1ns / 1ps

package sts_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int KEY_WIDTH   = 32;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;       // holds 0..TABLE_DEPTH

    localparam int IN_INDEX_W  = 10;
    localparam int IN_KEY_W    = 32;
    localparam int CFG_W       = 11;
    localparam int OUT_INDEX_W = 10;

    // command queue between front and back, depth must be a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef struct packed {
        logic                        op;
        logic [ADDR_W-1:0]           addr;   // write address, unused on search
        logic signed [KEY_WIDTH-1:0] key;    // stored value or search key
    } item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    // fit a 32-bit signed field to the table key width
    function automatic logic signed [KEY_WIDTH-1:0] norm_key(
        input logic signed [IN_KEY_W-1:0] v
    );
        return KEY_WIDTH'(v);
    endfunction

endpackage

[hw/rtl/sorted_table_search.sv]
// sorted_table_search: top level, binary search over a loaded key table.
// Depends on sts_pkg, sts_front, sts_queue, sts_back.
//
//  channel  handshake            payload
//  input    start / busy         op, entry_index, entry_value, search_key
//  config   cfg_we               cfg_data (entries_in_use)
//  result   done (one cycle)     found, found_index
//
// A write transaction finishes in the back end when it is popped; a search is
// dispatched from the idle state and then probes the table, at most 11 probes
// over 1024 entries. The probe loop (one key table read and one compare per
// cycle) sets how long a search takes. A two-entry queue lets the front take
// transactions while a search runs; busy is high only when the queue is full.
// Reset clears control state and entries_in_use; the key table is not cleared.
// Results cannot be stalled: done marks each one for exactly one cycle.
`timescale 1ns / 1ps

module sorted_table_search
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                op,
    input  logic [sts_pkg::IN_INDEX_W-1:0]      entry_index,
    input  logic signed [sts_pkg::IN_KEY_W-1:0] entry_value,
    input  logic signed [sts_pkg::IN_KEY_W-1:0] search_key,
    input  logic                                cfg_we,
    input  logic [sts_pkg::CFG_W-1:0]           cfg_data,
    output logic                                done,
    output logic                                found,
    output logic [sts_pkg::OUT_INDEX_W-1:0]     found_index
);

    logic [sts_pkg::CFG_W-1:0] entries_in_use_reg;
    logic                      push;
    logic                      pop;
    sts_pkg::item_t            push_item;
    sts_pkg::item_t            head_item;
    sts_pkg::q_status_t        q_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_in_use_reg <= '0;
        end
        else if (cfg_we)
        begin
            entries_in_use_reg <= cfg_data;
        end
    end

    sts_front u_front
    (
        .start       (start),
        .op          (op),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .search_key  (search_key),
        .q_status    (q_status),
        .busy        (busy),
        .push        (push),
        .push_item   (push_item)
    );

    sts_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_status  (q_status)
    );

    sts_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_item      (head_item),
        .q_status       (q_status),
        .entries_in_use (entries_in_use_reg),
        .pop            (pop),
        .done           (done),
        .found          (found),
        .found_index    (found_index)
    );

endmodule

[hw/rtl/sts_front.sv]
// sts_front: accepts transactions and classifies them into queue items.
// Depends on sts_pkg.
`timescale 1ns / 1ps

module sts_front
(
    input  logic                               start,
    input  logic                               op,
    input  logic [sts_pkg::IN_INDEX_W-1:0]     entry_index,
    input  logic signed [sts_pkg::IN_KEY_W-1:0] entry_value,
    input  logic signed [sts_pkg::IN_KEY_W-1:0] search_key,
    input  sts_pkg::q_status_t                 q_status,
    output logic                               busy,
    output logic                               push,
    output sts_pkg::item_t                     push_item
);

    logic accept;
    logic in_range;

    assign busy   = q_status.full;
    assign accept = start && !q_status.full;

    assign in_range = 32'(entry_index) < 32'(sts_pkg::TABLE_DEPTH);

    // writes beyond the table are dropped here
    assign push = accept && ((op == sts_pkg::OP_SEARCH) || in_range);

    always_comb
    begin
        push_item.op   = op;
        push_item.addr = sts_pkg::ADDR_W'(entry_index);
        if (op == sts_pkg::OP_SEARCH)
        begin
            push_item.key = sts_pkg::norm_key(search_key);
        end
        else
        begin
            push_item.key = sts_pkg::norm_key(entry_value);
        end
    end

endmodule

[hw/rtl/sts_queue.sv]
// sts_queue: small FIFO of classified items between front and back.
// Depends on sts_pkg.
`timescale 1ns / 1ps

module sts_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  sts_pkg::item_t     push_item,
    input  logic               pop,
    output sts_pkg::item_t     head_item,
    output sts_pkg::q_status_t q_status
);

    sts_pkg::item_t                 slot_reg [sts_pkg::QUEUE_DEPTH];
    logic [sts_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [sts_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [sts_pkg::QCNT_W-1:0]     count_reg;
    logic [sts_pkg::QCNT_W-1:0]     count_next;
    logic                           do_push;
    logic                           do_pop;

    assign q_status.empty = (count_reg == '0);
    assign q_status.full  = (count_reg == sts_pkg::QCNT_W'(sts_pkg::QUEUE_DEPTH));
    assign do_push = push && !q_status.full;
    assign do_pop  = pop && !q_status.empty;
    assign head_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[hw/rtl/sts_back.sv]
// sts_back: key table memory and the binary search sequencer.
// Depends on sts_pkg; pops items from sts_queue.
`timescale 1ns / 1ps

module sts_back
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  sts_pkg::item_t                  head_item,
    input  sts_pkg::q_status_t              q_status,
    input  logic [sts_pkg::CFG_W-1:0]       entries_in_use,
    output logic                            pop,
    output logic                            done,
    output logic                            found,
    output logic [sts_pkg::OUT_INDEX_W-1:0] found_index
);

    localparam int AW = sts_pkg::ADDR_W;
    localparam int CW = sts_pkg::CNT_W;
    localparam int KW = sts_pkg::KEY_WIDTH;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_PROBE = 1'b1;

    logic                   state_reg, state_next;
    logic signed [AW+1:0]   lo_reg, lo_next;
    logic signed [AW+1:0]   hi_reg, hi_next;
    logic [AW-1:0]          mid_reg, mid_next;
    logic signed [KW-1:0]   key_reg, key_next;
    logic                   done_reg, done_next;
    logic                   found_reg, found_next;
    logic [sts_pkg::OUT_INDEX_W-1:0] index_reg, index_next;

    logic signed [KW-1:0]   key_table [sts_pkg::TABLE_DEPTH];
    logic signed [KW-1:0]   rdata_reg;
    logic                   mem_we;

    logic [31:0]            n_wide;
    logic [CW-1:0]          n_sat;
    logic [CW-1:0]          n_minus1;
    logic signed [AW+1:0]   lo_try, hi_try;
    logic signed [AW+1:0]   sum;

    assign n_wide   = (32'(entries_in_use) > 32'(sts_pkg::TABLE_DEPTH))
                      ? 32'(sts_pkg::TABLE_DEPTH) : 32'(entries_in_use);
    assign n_sat    = CW'(n_wide);
    assign n_minus1 = n_sat - 1'b1;
    assign sum      = lo_try + hi_try;

    assign pop    = (state_reg == ST_IDLE) && !q_status.empty;
    assign mem_we = pop && (head_item.op == sts_pkg::OP_WRITE);

    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        key_next   = key_reg;
        done_next  = 1'b0;
        found_next = found_reg;
        index_next = index_reg;
        lo_try     = lo_reg;
        hi_try     = hi_reg;

        case (state_reg)
            ST_IDLE:
            begin
                lo_try = '0;
                hi_try = $signed({1'b0, n_minus1});
                mid_next = n_minus1[AW:1];
                if (pop && (head_item.op == sts_pkg::OP_SEARCH))
                begin
                    key_next = head_item.key;
                    lo_next  = lo_try;
                    hi_next  = hi_try;
                    if (n_sat == '0)
                    begin
                        done_next  = 1'b1;
                        found_next = 1'b0;
                        index_next = '0;
                    end
                    else
                    begin
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_PROBE:
            begin
                if (rdata_reg == key_reg)
                begin
                    done_next  = 1'b1;
                    found_next = 1'b1;
                    index_next = sts_pkg::OUT_INDEX_W'(mid_reg);
                    state_next = ST_IDLE;
                end
                else
                begin
                    if (rdata_reg > key_reg)
                    begin
                        hi_try = $signed({2'b00, mid_reg}) - 2'sd1;
                    end
                    else
                    begin
                        lo_try = $signed({2'b00, mid_reg}) + 2'sd1;
                    end
                    lo_next  = lo_try;
                    hi_next  = hi_try;
                    // sum is non-negative whenever the range is still open
                    mid_next = sum[AW:1];
                    if (lo_try > hi_try)
                    begin
                        done_next  = 1'b1;
                        found_next = 1'b0;
                        index_next = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        key_reg   <= key_next;
        found_reg <= found_next;
        index_reg <= index_next;
    end

    // one write port, one registered read port; read follows the next probe
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_table[head_item.addr] <= head_item.key;
        end
        rdata_reg <= key_table[mid_next];
    end

    assign done        = done_reg;
    assign found       = found_reg;
    assign found_index = index_reg;

endmodule

[tb/sts_checker.sv]
// sts_checker: watches the transaction and result channels of sorted_table_search.
// It keeps its own key table and entry count, predicts every lookup and compares.
// Depends on sts_pkg.
`timescale 1ns / 1ps

module sts_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic                                op,
    input  logic [sts_pkg::IN_INDEX_W-1:0]      entry_index,
    input  logic signed [sts_pkg::IN_KEY_W-1:0] entry_value,
    input  logic signed [sts_pkg::IN_KEY_W-1:0] search_key,
    input  logic                                cfg_we,
    input  logic [sts_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                done,
    input  logic                                found,
    input  logic [sts_pkg::OUT_INDEX_W-1:0]     found_index,
    output int                                  fail_count,
    output int                                  outstanding
);
    import sts_pkg::*;

    typedef struct packed {
        logic                   hit;
        logic [OUT_INDEX_W-1:0] index;
    } lookup_t;

    logic signed [KEY_WIDTH-1:0] key_copy [TABLE_DEPTH];
    logic [CFG_W-1:0]            entries_copy;
    lookup_t                     lookups_due [$];

    // halving search over the covered entries, first equal probe wins
    function automatic lookup_t predict_lookup(logic signed [IN_KEY_W-1:0] raw_key);
        logic signed [KEY_WIDTH-1:0] probe_key;
        int                          lo;
        int                          hi;
        int                          mid;
        lookup_t                     r;
        probe_key = raw_key;
        r         = '0;
        lo        = 0;
        if (entries_copy > TABLE_DEPTH)
            hi = TABLE_DEPTH - 1;
        else
            hi = int'(entries_copy) - 1;
        while (lo <= hi && !r.hit)
        begin
            mid = (lo + hi) / 2;
            if (key_copy[mid] == probe_key)
            begin
                r.hit   = 1'b1;
                r.index = OUT_INDEX_W'(mid);
            end
            else if (key_copy[mid] > probe_key)
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        lookup_t want;
        lookup_t got;
        if (!rst_n)
        begin
            entries_copy <= '0;
            lookups_due.delete();
            outstanding  <= 0;
            fail_count   <= 0;
        end
        else
        begin
            if (cfg_we)
                entries_copy <= cfg_data;

            if (done)
            begin
                got.hit   = found;
                got.index = found_index;
                if (lookups_due.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: unexpected result found=%0b index=%0d",
                                 $time, found, found_index);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = lookups_due.pop_front();
                    if (got !== want)
                    begin
                        if (fail_count < 10)
                            $display("%0t: mismatch exp found=%0b index=%0d, %s%0b index=%0d",
                                     $time, want.hit, want.index, "got found=",
                                     got.hit, got.index);
                        fail_count <= fail_count + 1;
                    end
                end
            end

            if (start && !busy)
            begin
                if (op == OP_WRITE)
                    key_copy[entry_index] <= entry_value;
                else
                    lookups_due.push_back(predict_lookup(search_key));
            end

            outstanding <= lookups_due.size();
        end
    end

endmodule

[tb/tb.sv]
// tb: stimulus and verdict for sorted_table_search.
// Loads sorted key tables, runs directed and random lookups at several entry counts.
// Depends on sts_pkg, sorted_table_search and sts_checker.
`timescale 1ns / 1ps

module tb;
    import sts_pkg::*;

    localparam int DRAIN        = 48;
    localparam int LIMIT        = 400000;
    localparam int RANDOM_ITEMS = 40;
    localparam int ITEMS_TARGET = 1100;

    localparam logic signed [IN_KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [IN_KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic                        op;
    logic [IN_INDEX_W-1:0]       entry_index;
    logic signed [IN_KEY_W-1:0]  entry_value;
    logic signed [IN_KEY_W-1:0]  search_key;
    logic                        cfg_we;
    logic [CFG_W-1:0]            cfg_data;
    logic                        done;
    logic                        found;
    logic [OUT_INDEX_W-1:0]      found_index;

    int                          fail_count;
    int                          outstanding;

    // what the tb has written, so lookups target stored keys
    logic signed [IN_KEY_W-1:0]  key_shadow [TABLE_DEPTH];
    bit                          loaded [TABLE_DEPTH];
    logic [CFG_W-1:0]            entries_now;
    int                          idle_pct;
    int                          items_sent;

    always #5 clk = ~clk;

    sorted_table_search dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .search_key  (search_key),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .done        (done),
        .found       (found),
        .found_index (found_index)
    );

    sts_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .search_key  (search_key),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .done        (done),
        .found       (found),
        .found_index (found_index),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // idle rate follows the share of the run already sent
    task automatic pace();
        if (items_sent < ITEMS_TARGET / 3)
            idle_pct = 18;
        else if (items_sent < 2 * ITEMS_TARGET / 3)
            idle_pct = 53;
        else
            idle_pct = 0;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
    endtask

    // one transaction; the field the op does not use carries noise
    task automatic send(logic cmd, int idx, logic signed [IN_KEY_W-1:0] value);
        logic [IN_INDEX_W-1:0] slot;
        slot        = IN_INDEX_W'(idx);
        start       <= 1'b1;
        op          <= cmd;
        entry_index <= slot;
        entry_value <= (cmd == OP_WRITE) ? value : $urandom;
        search_key  <= (cmd == OP_SEARCH) ? value : $urandom;
        do
            @(posedge clk);
        while (busy);
        if (cmd == OP_WRITE)
        begin
            key_shadow[slot] = value;
            loaded[slot]     = 1'b1;
        end
        items_sent++;
        pace();
    endtask

    task automatic hold_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // writes give no result, so let queued writes finish before touching the count
    task automatic set_entries(int n);
        hold_results();
        repeat (DRAIN) @(posedge clk);
        hold_results();
        cfg_we   <= 1'b1;
        cfg_data <= CFG_W'(n);
        @(posedge clk);
        cfg_we      <= 1'b0;
        entries_now = CFG_W'(n);
    endtask

    task automatic load_sorted(int n);
        longint v;
        longint span;
        case ($urandom_range(2))
            0:
            begin
                span = 64'h1_0000_0000 / n;
                v    = longint'(KEY_MIN);
            end
            1:
            begin
                span = 2;        // many repeated keys
                v    = longint'($signed($urandom));
            end
            default:
            begin
                span = 1000;
                v    = longint'($signed($urandom));
            end
        endcase
        if (span > 64'hFFFF_FFFF)
            span = 64'hFFFF_FFFF;
        for (int i = 0; i < n; i++)
        begin
            send(OP_WRITE, i, v[IN_KEY_W-1:0]);
            v = v + longint'($urandom_range(32'(span)));
            if (v > KEY_MAX)
                v = longint'(KEY_MAX);
        end
    endtask

    function automatic logic signed [IN_KEY_W-1:0] pick_key(int n);
        logic signed [IN_KEY_W-1:0] k;
        int                         roll;
        roll = $urandom_range(99);
        k    = (n > 0) ? key_shadow[$urandom_range(n - 1)] : $urandom;
        if (roll >= 88)
        begin
            case ($urandom_range(3))
                0:       k = KEY_MIN;
                1:       k = KEY_MAX;
                2:       k = 0;
                default: k = -1;
            endcase
        end
        else if (roll >= 70)
            k = $urandom;
        else if (roll >= 55)
            k = $urandom_range(1) ? k + 1 : k - 1;
        return k;
    endfunction

    task automatic search_burst(int count, bit noisy);
        int n_eff;
        int roll;
        n_eff = (entries_now > TABLE_DEPTH) ? TABLE_DEPTH : int'(entries_now);
        repeat (count)
        begin
            roll = $urandom_range(99);
            if (noisy && roll < 6 && n_eff > 0)
                send(OP_WRITE, $urandom_range(n_eff - 1), $urandom);  // breaks the order
            else if (noisy && roll < 10)
                send(OP_WRITE, $urandom, $urandom);
            else if (noisy && roll < 12)
                hold_results();
            else
                send(OP_SEARCH, $urandom, pick_key(n_eff));
        end
    endtask

    initial
    begin : watchdog
        repeat (LIMIT) @(posedge clk);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int base;
        int roll;
        int n;
        int prefix;

        rst_n       <= 1'b0;
        start       <= 1'b0;
        op          <= OP_WRITE;
        entry_index <= '0;
        entry_value <= '0;
        search_key  <= '0;
        cfg_we      <= 1'b0;
        cfg_data    <= '0;
        entries_now = '0;
        idle_pct    = 18;
        items_sent  = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // empty table
        set_entries(0);
        send(OP_SEARCH, $urandom, 0);
        send(OP_SEARCH, $urandom, KEY_MAX);

        // key extremes
        send(OP_WRITE, 0, KEY_MIN);
        send(OP_WRITE, 1, -1);
        send(OP_WRITE, 2, 0);
        send(OP_WRITE, 3, KEY_MAX);
        set_entries(4);
        send(OP_SEARCH, $urandom, KEY_MIN);
        send(OP_SEARCH, $urandom, -1);
        send(OP_SEARCH, $urandom, 0);
        send(OP_SEARCH, $urandom, KEY_MAX);
        send(OP_SEARCH, $urandom, 5);
        send(OP_SEARCH, $urandom, -2);

        set_entries(1);
        send(OP_SEARCH, $urandom, KEY_MIN);
        send(OP_SEARCH, $urandom, 0);

        // repeated keys: the first probe lands on index 1
        for (int i = 0; i < 4; i++)
            send(OP_WRITE, i, 7);
        set_entries(4);
        send(OP_SEARCH, $urandom, 7);

        // unsorted: a large key at the front is never probed
        send(OP_WRITE, 0, 100);
        send(OP_SEARCH, $urandom, 100);
        send(OP_SEARCH, $urandom, 7);
        send(OP_WRITE, TABLE_DEPTH - 1, 32'sh5555_AAAA);

        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS)
        begin
            roll = $urandom_range(99);
            if (roll < 6)
                set_entries(0);
            else if (roll < 20)
            begin
                // reuse what is stored, never reaching past the written prefix
                prefix = 0;
                while (prefix < TABLE_DEPTH && loaded[prefix])
                    prefix++;
                set_entries($urandom_range(prefix));
            end
            else
            begin
                if (roll < 75)
                    n = $urandom_range(16, 1);
                else if (roll < 93)
                    n = $urandom_range(100, 17);
                else
                    n = $urandom_range(250, 101);
                load_sorted(n);
                set_entries(n);
            end
            search_burst($urandom_range(40, 8), 1'b1);
        end

        // full table, then counts at, above and just below the depth
        load_sorted(TABLE_DEPTH);
        set_entries(TABLE_DEPTH);
        search_burst(20, 1'b0);
        set_entries(11'h7FF);
        search_burst(10, 1'b0);
        set_entries($urandom_range(2046, TABLE_DEPTH + 1));
        search_burst(10, 1'b1);
        set_entries(TABLE_DEPTH - 1);
        search_burst(10, 1'b1);

        hold_results();
        repeat (DRAIN) @(posedge clk);
        hold_results();
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/sts_pkg.sv
hw/rtl/sts_front.sv
hw/rtl/sts_queue.sv
hw/rtl/sts_back.sv
hw/rtl/sorted_table_search.sv
tb/sts_checker.sv
tb/tb.sv
